@@ design/bsd_pkg.sv @@
// shared types, constants and the character-to-sextet map of the base64 stream decoder
`default_nettype none

package bsd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // up to three decoded bytes of one group, first byte in slot 0
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            fin;
  } grp_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
      d = 8'd62;
    end else if (c == 8'h2C || c == 8'h2F || c == 8'h5F) begin
      d = 8'd63;
    end
    return d[5:0];
  endfunction

endpackage

`default_nettype wire

@@ design/base64_stream_decoder.sv @@
// top level of the base64 stream decoder: input register, decode and byte output
// an item is accepted into the input register and decoded there; its bytes load the
// output register as it moves on, making the first byte valid; unless stalled, one
// character is taken per cycle and a group's bytes leave one per cycle, so a character
// that yields bytes waits until the output register is empty or gives up its last byte
// synchronous reset empties both registers and clears the group state
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       symbol_valid,
  output logic            symbol_stall,
  input  wire logic [7:0] symbol,
  input  wire logic       final_symbol,
  output logic            byte_valid,
  input  wire logic       byte_stall,
  output logic [7:0]      out_byte,
  output logic            last_byte
);
  import bsd_pkg::*;

  logic       in_full;
  logic [7:0] sym_q;
  logic       fin_q;
  logic       adv;
  logic       free;
  logic       accept;
  grp_t       dec_grp;

  assign adv          = in_full && (dec_grp.count == 2'd0 || free);
  assign symbol_stall = in_full && !adv;
  assign accept       = symbol_valid && !symbol_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q <= symbol;
      fin_q <= final_symbol;
    end
  end

  bsd_decode u_decode (
    .clk (clk),
    .rst (rst),
    .sym (sym_q),
    .fin (fin_q),
    .adv (adv),
    .grp (dec_grp)
  );

  bsd_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (adv && dec_grp.count != 2'd0),
    .grp        (dec_grp),
    .free       (free),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

  // characters that yield no bytes never hold up the input
  assert property (@(posedge clk) disable iff (rst)
    in_full && dec_grp.count == 2'd0 |-> !symbol_stall)
    else $error("byte-free item stalled");

  // a held item keeps its character until it moves on
  assert property (@(posedge clk) disable iff (rst)
    in_full && !adv |=> in_full && $stable(sym_q) && $stable(fin_q))
    else $error("held item lost");

  // only a final character yields a short group
  assert property (@(posedge clk) disable iff (rst)
    adv && !fin_q && dec_grp.count != 2'd0 |-> dec_grp.count == 2'd3)
    else $error("short non-final group");

endmodule

`default_nettype wire

@@ design/bsd_decode.sv @@
// group state and decode of one character into zero to three bytes
`default_nettype none

module bsd_decode (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  sym,
  input  wire logic        fin,
  input  wire logic        adv,
  output bsd_pkg::grp_t    grp
);
  import bsd_pkg::*;

  logic [17:0] acc;
  logic [1:0]  pos;
  logic        third_pad;

  logic [5:0]  s;
  logic [23:0] n;
  logic [23:0] aligned;
  logic        pad;

  assign s   = sextet_of(sym);
  assign n   = {acc, s};
  assign pad = (sym == PAD_CHAR);

  always_comb begin
    case (pos)
      2'd0:    aligned = {s, 18'd0};
      2'd1:    aligned = {acc[5:0], s, 12'd0};
      2'd2:    aligned = {acc[11:0], s, 6'd0};
      default: aligned = n;
    endcase
  end

  always_comb begin
    grp.data[0] = aligned[23:16];
    grp.data[1] = aligned[15:8];
    grp.data[2] = aligned[7:0];
    grp.fin     = fin;
    if (!fin) begin
      grp.count = (pos == 2'd3) ? 2'd3 : 2'd0;
    end else begin
      case (pos)
        2'd0, 2'd1: grp.count = 2'd1;
        2'd2:       grp.count = pad ? 2'd1 : 2'd2;
        default: begin
          if (!pad) grp.count = 2'd3;
          else      grp.count = third_pad ? 2'd1 : 2'd2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pos       <= '0;
      third_pad <= 1'b0;
    end else if (adv) begin
      if (fin || pos == 2'd3) begin
        acc       <= '0;
        pos       <= '0;
        third_pad <= 1'b0;
      end else begin
        acc <= n[17:0];
        pos <= pos + 2'd1;
        if (pos == 2'd2) third_pad <= pad;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bsd_serializer.sv @@
// output register that holds one decoded group and hands out its bytes one at a time
`default_nettype none

module bsd_serializer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire bsd_pkg::grp_t grp,
  output logic               free,
  output logic               byte_valid,
  input  wire logic          byte_stall,
  output logic [7:0]         out_byte,
  output logic               last_byte
);
  import bsd_pkg::*;

  logic [2:0][7:0] data;
  logic [1:0]      count;
  logic            fin;
  logic            take;

  assign byte_valid = (count != 2'd0);
  assign take       = byte_valid && !byte_stall;
  // free now, or the last held byte leaves at this edge
  assign free       = (count == 2'd0) || (count == 2'd1 && take);
  assign out_byte   = data[0];
  assign last_byte  = fin && (count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fin   <= 1'b0;
    end else if (load) begin
      data  <= grp.data;
      count <= grp.count;
      fin   <= grp.fin;
    end else if (take) begin
      data[0] <= data[1];
      data[1] <= data[2];
      count   <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench for the base64 stream decoder
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       symbol_valid = 1'b0;
  logic       symbol_stall;
  logic [7:0] symbol = 8'h00;
  logic       final_symbol = 1'b0;
  logic       byte_valid;
  logic       byte_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last_byte;

  // own copy of the decoder state
  logic [17:0] group_bits = '0;
  logic [1:0]  group_fill = '0;
  logic        third_pad = 1'b0;

  decoded_byte_t pending_bytes[$];
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  base64_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .symbol_valid(symbol_valid),
    .symbol_stall(symbol_stall),
    .symbol(symbol),
    .final_symbol(final_symbol),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .out_byte(out_byte),
    .last_byte(last_byte)
  );

  always #2 clk = ~clk;

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else begin
      case (c)
        8'h2B, 8'h2D, 8'h2E: v = 8'd62;
        8'h2C, 8'h2F, 8'h5F: v = 8'd63;
        default: v = 8'd0;
      endcase
    end
    return v[5:0];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    decoded_byte_t r;
    r.data = b;
    r.last = is_last;
    pending_bytes = {pending_bytes, r};
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [5:0]  s;
    logic [23:0] word;
    s = char_to_sextet(c);
    word = {group_bits, s};
    if (!fin) begin
      if (group_fill == 2'd3) begin
        push_byte(word[23:16], 1'b0);
        push_byte(word[15:8], 1'b0);
        push_byte(word[7:0], 1'b0);
        group_bits = '0;
        group_fill = '0;
        third_pad = 1'b0;
      end else begin
        if (group_fill == 2'd2) third_pad = (c == PAD_CHAR);
        group_bits = word[17:0];
        group_fill = group_fill + 2'd1;
      end
    end else begin
      // left-align the partial group in a 24-bit word
      word = word << (6 * (3 - group_fill));
      if (group_fill <= 2'd1) begin
        push_byte(word[23:16], 1'b1);
      end else if (group_fill == 2'd2) begin
        if (c != PAD_CHAR) begin
          push_byte(word[23:16], 1'b0);
          push_byte(word[15:8], 1'b1);
        end else begin
          push_byte(word[23:16], 1'b1);
        end
      end else if (c == PAD_CHAR) begin
        if (!third_pad) begin
          push_byte(word[23:16], 1'b0);
          push_byte(word[15:8], 1'b1);
        end else begin
          push_byte(word[23:16], 1'b1);
        end
      end else begin
        push_byte(word[23:16], 1'b0);
        push_byte(word[15:8], 1'b0);
        push_byte(word[7:0], 1'b1);
      end
      group_bits = '0;
      group_fill = '0;
      third_pad = 1'b0;
    end
  endtask

  // output check first, then prediction of the item taken at the same edge
  always @(posedge clk) begin
    decoded_byte_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got %02h last %0b",
                   $time, out_byte, last_byte);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.data || last_byte !== want.last) begin
            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                     $time, want.data, want.last, out_byte, last_byte);
            errors++;
          end
        end
      end
      if (symbol_valid && !symbol_stall) decode_char(symbol, final_symbol);
      if ((byte_valid && !byte_stall) || (symbol_valid && !symbol_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    byte_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      symbol_valid <= 1'b0;
      @(negedge clk);
    end
    symbol_valid <= 1'b1;
    symbol <= c;
    final_symbol <= fin;
    @(posedge clk);
    while (symbol_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_char();
    string alphabet;
    int r;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_.,=";
    r = $urandom_range(0, 99);
    if (r < 10) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  // one text of random length, closed by a final character, often with tail padding
  task automatic send_random_text(output int n);
    int tail;
    logic [7:0] c;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    tail = $urandom_range(0, 99);
    for (int i = 0; i < n; i++) begin
      c = pick_char();
      if (tail >= 60 && i == n - 1) c = PAD_CHAR;
      if (tail >= 80 && tail < 95 && i == n - 2) c = PAD_CHAR;
      send_char(c, i == n - 1);
    end
  endtask

  task automatic wait_for_bytes();
    @(negedge clk);
    symbol_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_group_tails();
    send_char(8'hFF, 1'b1);
    send_text("_-", 1'b1);
    send_text("Zz9", 1'b1);
    send_text("ab=", 1'b1);
    send_text("AB==", 1'b1);
    send_text("AbC=", 1'b1);
    send_text(",/+.", 1'b1);
  endtask

  task automatic test_inner_padding();
    send_text("a===", 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_texts(input int count);
    int n;
    int done;
    done = 0;
    while (done < count) begin
      send_random_text(n);
      done += n;
    end
  endtask

  task automatic test_drain_pause();
    int n;
    for (int k = 0; k < 3; k++) begin
      send_random_text(n);
      wait_for_bytes();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_group_tails();
    test_inner_padding();

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_texts(105);

    send_idle_pct = 81;
    stall_pct = 0;
    test_random_texts(105);
    test_drain_pause();

    send_idle_pct = 0;
    stall_pct = 81;
    test_random_texts(105);

    send_idle_pct = 14;
    stall_pct = 14;
    test_random_texts(105);

    wait_for_bytes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
